// ----- design/spectral_vorticity_mode_stage_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the spectral vorticity mode stage.
// Clocked property helpers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_VORTICITY_MODE_STAGE_ASSERT_SVH
`define SPECTRAL_VORTICITY_MODE_STAGE_ASSERT_SVH

`define SVM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SVM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define SVM_ASSERT_NXT_RAW(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/svm_pkg.sv -----
// ----------------------------------------------------------------------------
// svm_pkg
// Constants, types and arithmetic helpers of the spectral vorticity stage.
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam int GRID_X    = 64;
    localparam int GRID_Y    = 64;
    localparam int PAD_X     = GRID_X * 3 / 2;
    localparam int WRAP_X    = GRID_X * 3 / 4;
    localparam int BAND_X_LO = GRID_X / 2;
    localparam int BAND_Y    = GRID_Y / 2;
    localparam int MAX_Y     = GRID_Y * 3 / 4;

    localparam int DIV_STAGES = 32;

    localparam logic [1:0] REG_TIME_STEP = 2'd0;
    localparam logic [1:0] REG_VISCOSITY = 2'd1;
    localparam logic [1:0] REG_WAVE_X    = 2'd2;
    localparam logic [1:0] REG_WAVE_Y    = 2'd3;

    localparam logic [30:0] RST_TIME_STEP = 31'd655;
    localparam logic [30:0] RST_VISCOSITY = 31'd66;
    localparam logic [30:0] RST_WAVE_X    = 31'd65536;
    localparam logic [30:0] RST_WAVE_Y    = 31'd65536;

    localparam logic [1:0] STAGE_PLAIN  = 2'd0;
    localparam logic [1:0] STAGE_HALF_A = 2'd1;
    localparam logic [1:0] STAGE_HALF_B = 2'd2;
    localparam logic [1:0] STAGE_FULL   = 2'd3;

    localparam logic [4:0] SH_Q    = 5'd16;
    localparam logic [4:0] SH_HALF = 5'd17;

    typedef logic signed [31:0] t_q;

    typedef struct packed {
        logic        band;
        t_q          wr;
        t_q          wi;
        t_q          kx;
        t_q          ky;
        logic [30:0] ksq;
        logic [30:0] rem_re;
        logic [30:0] rem_im;
        logic [31:0] sh_re;
        logic [31:0] sh_im;
        logic        ovf_re;
        logic        ovf_im;
    } t_div_item;

    function automatic t_q sat_s(input logic signed [64:0] v);
        if (v > 65'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -65'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_q rnd_sat(input logic signed [63:0] p, input logic [4:0] sh);
        logic [63:0] mag;
        logic [63:0] half;
        logic [63:0] r;
        mag  = p[63] ? 64'(-p) : 64'(p);
        half = 64'd1 << (sh - 5'd1);
        r    = (mag + half) >> sh;
        if (p[63]) begin
            return sat_s(-$signed({1'b0, r}));
        end
        return sat_s($signed({1'b0, r}));
    endfunction

    function automatic t_div_item div_step(input t_div_item x, input logic first);
        t_div_item   y;
        logic [31:0] tr;
        logic [31:0] ti;
        logic        ger;
        logic        gei;
        y = x;
        if (first) begin
            y.ovf_re = x.rem_re >= x.ksq;
            y.ovf_im = x.rem_im >= x.ksq;
        end
        tr  = {x.rem_re, x.sh_re[31]};
        ti  = {x.rem_im, x.sh_im[31]};
        ger = tr >= {1'b0, x.ksq};
        gei = ti >= {1'b0, x.ksq};
        y.rem_re = ger ? 31'(tr - {1'b0, x.ksq}) : tr[30:0];
        y.rem_im = gei ? 31'(ti - {1'b0, x.ksq}) : ti[30:0];
        y.sh_re  = {x.sh_re[30:0], ger};
        y.sh_im  = {x.sh_im[30:0], gei};
        return y;
    endfunction

    function automatic t_q psi_final(input logic [31:0] q, input logic ovf,
                                     input logic [30:0] ksq, input logic neg);
        logic big;
        big = ovf | q[31];
        if (ksq == 31'd0) begin
            return 32'sd0;
        end else if (neg) begin
            return big ? 32'sh80000000 : -$signed(q);
        end
        return big ? 32'sh7FFFFFFF : $signed(q);
    endfunction

endpackage

// ----- design/svm_channels.sv -----
// ----------------------------------------------------------------------------
// svm_in_if / svm_out_if
// Valid/ready channels carrying mode items in and derivative items out.
// ----------------------------------------------------------------------------
interface svm_in_if;
    logic               valid;
    logic               ready;
    logic [6:0]         mode_x;
    logic [5:0]         mode_y;
    logic [1:0]         stage;
    logic signed [31:0] vort_re;
    logic signed [31:0] vort_im;
    logic signed [31:0] slope_re;
    logic signed [31:0] slope_im;

    modport source (output valid, mode_x, mode_y, stage, vort_re, vort_im,
                    slope_re, slope_im, input ready);
    modport sink (input valid, mode_x, mode_y, stage, vort_re, vort_im,
                  slope_re, slope_im, output ready);
endinterface

interface svm_out_if;
    logic               valid;
    logic               ready;
    logic               in_zero_band;
    logic signed [31:0] dvort_dx_re;
    logic signed [31:0] dvort_dx_im;
    logic signed [31:0] dvort_dy_re;
    logic signed [31:0] dvort_dy_im;
    logic signed [31:0] dstream_dx_re;
    logic signed [31:0] dstream_dx_im;
    logic signed [31:0] dstream_dy_re;
    logic signed [31:0] dstream_dy_im;
    logic signed [31:0] diffusion_re;
    logic signed [31:0] diffusion_im;

    modport source (output valid, in_zero_band, dvort_dx_re, dvort_dx_im, dvort_dy_re,
                    dvort_dy_im, dstream_dx_re, dstream_dx_im, dstream_dy_re,
                    dstream_dy_im, diffusion_re, diffusion_im, input ready);
    modport sink (input valid, in_zero_band, dvort_dx_re, dvort_dx_im, dvort_dy_re,
                  dvort_dy_im, dstream_dx_re, dstream_dx_im, dstream_dy_re,
                  dstream_dy_im, diffusion_re, diffusion_im, output ready);
endinterface

// ----- design/svm_front.sv -----
// ----------------------------------------------------------------------------
// svm_front
// Band decision, stage vorticity, wave vector, k squared and divider setup.
// ----------------------------------------------------------------------------
module svm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic [30:0]          i_dt,
    input  logic [30:0]          i_wsx,
    input  logic [30:0]          i_wsy,
    svm_in_if.sink               i_in,
    output logic                 o_valid,
    output svm_pkg::t_div_item   o_item
);

    logic               r1_v, r2_v, r3_v, r4_v, r5_v;
    logic               r1_band, r2_band, r3_band, r4_band;
    logic [1:0]         r1_stage;
    svm_pkg::t_q        r1_vr, r1_vi;
    logic signed [63:0] r1_dsr, r1_dsi;
    logic signed [39:0] r1_kxp;
    logic [36:0]        r1_kyp;
    svm_pkg::t_q        r2_wr, r2_wi, r2_kx, r2_ky;
    svm_pkg::t_q        r3_wr, r3_wi, r3_kx, r3_ky;
    logic [63:0]        r3_sqx, r3_sqy;
    svm_pkg::t_q        r4_wr, r4_wi, r4_kx, r4_ky;
    logic [30:0]        r4_ksq;
    svm_pkg::t_div_item r5_item;

    logic               n1_band;
    logic signed [7:0]  wx;
    logic signed [63:0] dt_s;
    svm_pkg::t_q        n2_wr, n2_wi;
    logic [31:0]        ax, ay;
    logic [64:0]        sum;
    logic [49:0]        kr;
    logic [30:0]        n4_ksq;
    logic [31:0]        mr, mi;
    logic [47:0]        nr, ni;
    svm_pkg::t_div_item n5_item;

    assign i_in.ready = i_adv;

    always_comb begin
        n1_band = (int'(i_in.mode_x) > svm_pkg::BAND_X_LO && int'(i_in.mode_x) <= svm_pkg::GRID_X)
               || int'(i_in.mode_y) > svm_pkg::BAND_Y
               || int'(i_in.mode_x) >= svm_pkg::PAD_X
               || int'(i_in.mode_y) > svm_pkg::MAX_Y;
        if (int'(i_in.mode_x) <= svm_pkg::WRAP_X) begin
            wx = $signed(8'(i_in.mode_x));
        end else begin
            wx = $signed(8'(int'(i_in.mode_x) - svm_pkg::PAD_X));
        end
        dt_s = $signed({33'd0, i_dt});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_in.valid;
        end
        if (i_adv) begin
            r1_band  <= n1_band;
            r1_stage <= i_in.stage;
            r1_vr    <= i_in.vort_re;
            r1_vi    <= i_in.vort_im;
            r1_dsr   <= dt_s * 64'(i_in.slope_re);
            r1_dsi   <= dt_s * 64'(i_in.slope_im);
            r1_kxp   <= 40'($signed({1'b0, i_wsx})) * 40'(wx);
            r1_kyp   <= 37'(i_wsy) * 37'(i_in.mode_y);
        end
    end

    always_comb begin
        unique case (r1_stage)
            svm_pkg::STAGE_PLAIN: begin
                n2_wr = r1_vr;
                n2_wi = r1_vi;
            end
            svm_pkg::STAGE_HALF_A, svm_pkg::STAGE_HALF_B: begin
                n2_wr = svm_pkg::sat_s(65'(r1_vr) + 65'(svm_pkg::rnd_sat(r1_dsr, svm_pkg::SH_HALF)));
                n2_wi = svm_pkg::sat_s(65'(r1_vi) + 65'(svm_pkg::rnd_sat(r1_dsi, svm_pkg::SH_HALF)));
            end
            default: begin
                n2_wr = svm_pkg::sat_s(65'(r1_vr) + 65'(svm_pkg::rnd_sat(r1_dsr, svm_pkg::SH_Q)));
                n2_wi = svm_pkg::sat_s(65'(r1_vi) + 65'(svm_pkg::rnd_sat(r1_dsi, svm_pkg::SH_Q)));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_adv) begin
            r2_v <= r1_v;
        end
        if (i_adv) begin
            r2_band <= r1_band;
            r2_wr   <= n2_wr;
            r2_wi   <= n2_wi;
            r2_kx   <= svm_pkg::sat_s(65'(r1_kxp));
            r2_ky   <= svm_pkg::sat_s($signed({28'd0, r1_kyp}));
        end
    end

    always_comb begin
        ax = r2_kx[31] ? 32'(-r2_kx) : 32'(r2_kx);
        ay = r2_ky[31] ? 32'(-r2_ky) : 32'(r2_ky);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_adv) begin
            r3_v <= r2_v;
        end
        if (i_adv) begin
            r3_band <= r2_band;
            r3_wr   <= r2_wr;
            r3_wi   <= r2_wi;
            r3_kx   <= r2_kx;
            r3_ky   <= r2_ky;
            r3_sqx  <= 64'(ax) * 64'(ax);
            r3_sqy  <= 64'(ay) * 64'(ay);
        end
    end

    always_comb begin
        sum    = 65'(r3_sqx) + 65'(r3_sqy);
        kr     = 50'(sum[64:16]) + 50'(sum[15]);
        n4_ksq = (kr > 50'h7FFFFFFF) ? 31'h7FFFFFFF : kr[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_adv) begin
            r4_v <= r3_v;
        end
        if (i_adv) begin
            r4_band <= r3_band;
            r4_wr   <= r3_wr;
            r4_wi   <= r3_wi;
            r4_kx   <= r3_kx;
            r4_ky   <= r3_ky;
            r4_ksq  <= n4_ksq;
        end
    end

    always_comb begin
        mr = r4_wr[31] ? 32'(-r4_wr) : 32'(r4_wr);
        mi = r4_wi[31] ? 32'(-r4_wi) : 32'(r4_wi);
        nr = {mr[31:0], 16'd0} + 48'(r4_ksq >> 1);
        ni = {mi[31:0], 16'd0} + 48'(r4_ksq >> 1);
        n5_item.band   = r4_band;
        n5_item.wr     = r4_wr;
        n5_item.wi     = r4_wi;
        n5_item.kx     = r4_kx;
        n5_item.ky     = r4_ky;
        n5_item.ksq    = r4_ksq;
        n5_item.rem_re = 31'(nr[47:32]);
        n5_item.rem_im = 31'(ni[47:32]);
        n5_item.sh_re  = nr[31:0];
        n5_item.sh_im  = ni[31:0];
        n5_item.ovf_re = 1'b0;
        n5_item.ovf_im = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (i_adv) begin
            r5_v <= r4_v;
        end
        if (i_adv) begin
            r5_item <= n5_item;
        end
    end

    assign o_valid = r5_v;
    assign o_item  = r5_item;

endmodule

// ----- design/svm_div.sv -----
// ----------------------------------------------------------------------------
// svm_div
// Pipelined restoring divider, one quotient bit per stage for both parts.
// ----------------------------------------------------------------------------
module svm_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  svm_pkg::t_div_item   i_item,
    output logic                 o_valid,
    output svm_pkg::t_div_item   o_item
);

    svm_pkg::t_div_item r_item [svm_pkg::DIV_STAGES];
    svm_pkg::t_div_item n_item [svm_pkg::DIV_STAGES];
    logic [svm_pkg::DIV_STAGES-1:0] r_v;

    always_comb begin
        for (int j = 0; j < svm_pkg::DIV_STAGES; j++) begin
            if (j == 0) begin
                n_item[j] = svm_pkg::div_step(i_item, 1'b1);
            end else begin
                n_item[j] = svm_pkg::div_step(r_item[j-1], 1'b0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[svm_pkg::DIV_STAGES-2:0], i_valid};
        end
        if (i_adv) begin
            for (int j = 0; j < svm_pkg::DIV_STAGES; j++) begin
                r_item[j] <= n_item[j];
            end
        end
    end

    assign o_valid = r_v[svm_pkg::DIV_STAGES-1];
    assign o_item  = r_item[svm_pkg::DIV_STAGES-1];

endmodule

// ----- design/svm_back.sv -----
// ----------------------------------------------------------------------------
// svm_back
// Derivative and diffusion products, rounding and the output register.
// ----------------------------------------------------------------------------
module svm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [30:0]          i_nu,
    input  logic                 i_valid,
    input  svm_pkg::t_div_item   i_item,
    output logic                 o_adv,
    svm_out_if.source            o_out
);

    logic               r1_v, r2_v, r3_v, r4_v;
    logic               r1_band, r2_band, r3_band;
    svm_pkg::t_q        r1_pr, r1_pi, r1_kx, r1_ky, r1_wr, r1_wi;
    logic signed [63:0] r1_kxwr, r1_kxwi, r1_kywr, r1_kywi;
    logic [61:0]        r1_nuk;
    svm_pkg::t_q        r2_wr, r2_wi, r2_res0, r2_res1, r2_res2, r2_res3, r2_nk;
    logic signed [63:0] r2_kxpr, r2_kxpi, r2_kypr, r2_kypi;
    svm_pkg::t_q        r3_res0, r3_res1, r3_res2, r3_res3;
    svm_pkg::t_q        r3_res4, r3_res5, r3_res6, r3_res7;
    logic signed [63:0] r3_nwr, r3_nwi;
    logic               r4_band;
    svm_pkg::t_q        r4_res [10];

    svm_pkg::t_q        n1_pr, n1_pi;
    logic               adv;

    assign adv   = !r4_v || o_out.ready;
    assign o_adv = adv;

    always_comb begin
        n1_pr = svm_pkg::psi_final(i_item.sh_re, i_item.ovf_re, i_item.ksq, i_item.wr[31]);
        n1_pi = svm_pkg::psi_final(i_item.sh_im, i_item.ovf_im, i_item.ksq, i_item.wi[31]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
        if (adv) begin
            r1_band <= i_item.band;
            r1_pr   <= n1_pr;
            r1_pi   <= n1_pi;
            r1_kx   <= i_item.kx;
            r1_ky   <= i_item.ky;
            r1_wr   <= i_item.wr;
            r1_wi   <= i_item.wi;
            r1_kxwr <= 64'(i_item.kx) * 64'(i_item.wr);
            r1_kxwi <= 64'(i_item.kx) * 64'(i_item.wi);
            r1_kywr <= 64'(i_item.ky) * 64'(i_item.wr);
            r1_kywi <= 64'(i_item.ky) * 64'(i_item.wi);
            r1_nuk  <= 62'(i_nu) * 62'(i_item.ksq);

            r2_band <= r1_band;
            r2_wr   <= r1_wr;
            r2_wi   <= r1_wi;
            r2_res0 <= svm_pkg::rnd_sat(-r1_kxwi, svm_pkg::SH_Q);
            r2_res1 <= svm_pkg::rnd_sat(r1_kxwr, svm_pkg::SH_Q);
            r2_res2 <= svm_pkg::rnd_sat(-r1_kywi, svm_pkg::SH_Q);
            r2_res3 <= svm_pkg::rnd_sat(r1_kywr, svm_pkg::SH_Q);
            r2_nk   <= svm_pkg::rnd_sat($signed({2'b00, r1_nuk}), svm_pkg::SH_Q);
            r2_kxpr <= 64'(r1_kx) * 64'(r1_pr);
            r2_kxpi <= 64'(r1_kx) * 64'(r1_pi);
            r2_kypr <= 64'(r1_ky) * 64'(r1_pr);
            r2_kypi <= 64'(r1_ky) * 64'(r1_pi);

            r3_band <= r2_band;
            r3_res0 <= r2_res0;
            r3_res1 <= r2_res1;
            r3_res2 <= r2_res2;
            r3_res3 <= r2_res3;
            r3_res4 <= svm_pkg::rnd_sat(-r2_kxpi, svm_pkg::SH_Q);
            r3_res5 <= svm_pkg::rnd_sat(r2_kxpr, svm_pkg::SH_Q);
            r3_res6 <= svm_pkg::rnd_sat(-r2_kypi, svm_pkg::SH_Q);
            r3_res7 <= svm_pkg::rnd_sat(r2_kypr, svm_pkg::SH_Q);
            r3_nwr  <= 64'(-r2_nk) * 64'(r2_wr);
            r3_nwi  <= 64'(-r2_nk) * 64'(r2_wi);

            r4_band <= r3_band;
            if (r3_band) begin
                for (int j = 0; j < 10; j++) begin
                    r4_res[j] <= 32'sd0;
                end
            end else begin
                r4_res[0] <= r3_res0;
                r4_res[1] <= r3_res1;
                r4_res[2] <= r3_res2;
                r4_res[3] <= r3_res3;
                r4_res[4] <= r3_res4;
                r4_res[5] <= r3_res5;
                r4_res[6] <= r3_res6;
                r4_res[7] <= r3_res7;
                r4_res[8] <= svm_pkg::rnd_sat(r3_nwr, svm_pkg::SH_Q);
                r4_res[9] <= svm_pkg::rnd_sat(r3_nwi, svm_pkg::SH_Q);
            end
        end
    end

    assign o_out.valid         = r4_v;
    assign o_out.in_zero_band  = r4_band;
    assign o_out.dvort_dx_re   = r4_res[0];
    assign o_out.dvort_dx_im   = r4_res[1];
    assign o_out.dvort_dy_re   = r4_res[2];
    assign o_out.dvort_dy_im   = r4_res[3];
    assign o_out.dstream_dx_re = r4_res[4];
    assign o_out.dstream_dx_im = r4_res[5];
    assign o_out.dstream_dy_re = r4_res[6];
    assign o_out.dstream_dy_im = r4_res[7];
    assign o_out.diffusion_re  = r4_res[8];
    assign o_out.diffusion_im  = r4_res[9];

endmodule

// ----- design/spectral_vorticity_mode_stage.sv -----
// ----------------------------------------------------------------------------
// spectral_vorticity_mode_stage
// Per-mode kernel of a dealiased pseudo-spectral vorticity solver.
// ----------------------------------------------------------------------------
// Items enter on i_in (valid/ready) and leave on o_out (valid/ready). Each
// input item is one padded mode with its RK stage, vorticity and slope; each
// output item holds the band flag, the x and y derivatives of vorticity and
// stream function, and the diffusion term.
// The block takes one item per cycle while the output is not stalled. The
// pipeline has five front stages, 32 divider stages (one quotient bit each,
// which sets the depth) and four product and rounding stages ending in the output register.
// When the receiver holds o_out.ready low with a result waiting, the whole
// pipeline holds and i_in.ready falls; nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads the default time step,
// viscosity and wave scales. Registers sit at APB byte addresses 0, 4, 8 and
// 12; the user must write them only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module spectral_vorticity_mode_stage (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svm_in_if.sink      i_in,
    svm_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [30:0]        r_dt, r_nu, r_wsx, r_wsy;
    logic               adv;
    logic               f_valid, d_valid;
    svm_pkg::t_div_item f_item, d_item;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt  <= svm_pkg::RST_TIME_STEP;
            r_nu  <= svm_pkg::RST_VISCOSITY;
            r_wsx <= svm_pkg::RST_WAVE_X;
            r_wsy <= svm_pkg::RST_WAVE_Y;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                svm_pkg::REG_TIME_STEP: r_dt  <= pwdata[30:0];
                svm_pkg::REG_VISCOSITY: r_nu  <= pwdata[30:0];
                svm_pkg::REG_WAVE_X:    r_wsx <= pwdata[30:0];
                svm_pkg::REG_WAVE_Y:    r_wsy <= pwdata[30:0];
                default:                r_dt  <= r_dt;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            svm_pkg::REG_TIME_STEP: prdata = {1'b0, r_dt};
            svm_pkg::REG_VISCOSITY: prdata = {1'b0, r_nu};
            svm_pkg::REG_WAVE_X:    prdata = {1'b0, r_wsx};
            svm_pkg::REG_WAVE_Y:    prdata = {1'b0, r_wsy};
            default:                prdata = 32'd0;
        endcase
    end

    svm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_dt    (r_dt),
        .i_wsx   (r_wsx),
        .i_wsy   (r_wsy),
        .i_in    (i_in),
        .o_valid (f_valid),
        .o_item  (f_item)
    );

    svm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (f_valid),
        .i_item  (f_item),
        .o_valid (d_valid),
        .o_item  (d_item)
    );

    svm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_nu    (r_nu),
        .i_valid (d_valid),
        .i_item  (d_item),
        .o_adv   (adv),
        .o_out   (o_out)
    );

endmodule

// ----- design/svm_checker.sv -----
// ----------------------------------------------------------------------------
// svm_checker
// Port-level checks of the spectral vorticity mode stage, bound to the top.
// ----------------------------------------------------------------------------
`include "spectral_vorticity_mode_stage_assert.svh"

module svm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_band,
    input logic [31:0] i_out_dvx_re,
    input logic [31:0] i_out_dsy_im,
    input logic [31:0] i_out_diff_re,
    input logic        i_pready
);

    `SVM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `SVM_ASSERT_NXT_RAW(a_reset_empty, i_clk, !i_rst_n, !i_out_valid, "result present after reset")
    `SVM_ASSERT_IMP(a_band_zero, i_clk, i_rst_n, i_out_valid && i_out_band, i_out_dvx_re == 32'd0 && i_out_dsy_im == 32'd0 && i_out_diff_re == 32'd0, "band item not zero")
    `SVM_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready && i_pready, "input not ready with empty output")

endmodule

bind spectral_vorticity_mode_stage svm_checker u_svm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_band   (o_out.in_zero_band),
    .i_out_dvx_re (o_out.dvort_dx_re),
    .i_out_dsy_im (o_out.dstream_dy_im),
    .i_out_diff_re(o_out.diffusion_re),
    .i_pready     (pready)
);

// ----- tb/svm_mode_checker.sv -----
// ----------------------------------------------------------------------------
// svm_mode_checker
// Watches the mode and derivative channels of the spectral vorticity stage.
// ----------------------------------------------------------------------------
// Every accepted mode item is run through a bit-exact Q16.16 model of the
// stage: vorticity update, dealiasing band, wave vector, k squared, stream
// function and diffusion. The expected items wait in order and each
// accepted output item is compared field by field with the oldest one. The
// register values are tracked from reset and from the APB writes.
// ----------------------------------------------------------------------------
module svm_mode_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svm_in_if           i_modes,
    svm_out_if          i_derivs,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import svm_pkg::*;

    typedef struct {
        logic        band;
        logic [31:0] val[10];
    } t_deriv_item;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    string field_names[10] = '{"dvort_dx_re", "dvort_dx_im", "dvort_dy_re",
        "dvort_dy_im", "dstream_dx_re", "dstream_dx_im", "dstream_dy_re",
        "dstream_dy_im", "diffusion_re", "diffusion_im"};

    logic [30:0] dt_reg;
    logic [30:0] nu_reg;
    logic [30:0] scale_x_reg;
    logic [30:0] scale_y_reg;
    t_deriv_item expected_derivs[$];

    function automatic longint clamp_q(longint v);
        if (v > QMAX) begin
            return QMAX;
        end else if (v < QMIN) begin
            return QMIN;
        end
        return v;
    endfunction

    function automatic longint round_shift(longint p, int sh);
        logic                neg;
        longint unsigned     mag;
        longint              r;
        neg = p < 0;
        mag = neg ? -p : p;
        r = longint'((mag + (64'd1 << (sh - 1))) >> sh);
        return clamp_q(neg ? -r : r);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_shift(a * b, 16);
    endfunction

    function automatic t_deriv_item mode_derivs(logic [6:0] mx, logic [5:0] my,
                                                logic [1:0] stg, logic signed [31:0] vr,
                                                logic signed [31:0] vi, logic signed [31:0] sr,
                                                logic signed [31:0] si);
        t_deriv_item     r;
        longint          p;
        longint          q;
        longint          wr;
        longint          wi;
        longint          dt;
        longint          wx;
        longint          kx;
        longint          ky;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned sum;
        longint unsigned kr;
        longint unsigned mr;
        longint unsigned mi;
        longint          ksq;
        longint          pr;
        longint          pi;
        longint          nk;
        longint          v[10];
        p = mx;
        q = my;
        wr = vr;
        wi = vi;
        dt = dt_reg;
        r.band = 1'b0;
        if ((p > BAND_X_LO && p <= GRID_X) || q > BAND_Y || p >= PAD_X || q > MAX_Y) begin
            r.band = 1'b1;
            for (int n = 0; n < 10; n++) r.val[n] = '0;
            return r;
        end
        if (stg == STAGE_HALF_A || stg == STAGE_HALF_B) begin
            wr = clamp_q(wr + round_shift(dt * sr, 17));
            wi = clamp_q(wi + round_shift(dt * si, 17));
        end else if (stg == STAGE_FULL) begin
            wr = clamp_q(wr + round_shift(dt * sr, 16));
            wi = clamp_q(wi + round_shift(dt * si, 16));
        end
        wx = (p <= WRAP_X) ? p : p - PAD_X;
        kx = clamp_q(longint'(scale_x_reg) * wx);
        ky = clamp_q(longint'(scale_y_reg) * q);
        ax = kx < 0 ? -kx : kx;
        ay = ky < 0 ? -ky : ky;
        sum = ax * ax + ay * ay;
        kr = (sum >> 16) + ((sum >> 15) & 64'd1);
        ksq = kr > QMAX ? QMAX : longint'(kr);
        pr = 0;
        pi = 0;
        if (ksq != 0) begin
            mr = wr < 0 ? -wr : wr;
            mi = wi < 0 ? -wi : wi;
            pr = longint'(((mr << 16) + longint'(unsigned'(ksq)) / 2) / ksq);
            pi = longint'(((mi << 16) + longint'(unsigned'(ksq)) / 2) / ksq);
            pr = clamp_q(wr < 0 ? -pr : pr);
            pi = clamp_q(wi < 0 ? -pi : pi);
        end
        v[0] = qmul(-kx, wi);
        v[1] = qmul(kx, wr);
        v[2] = qmul(-ky, wi);
        v[3] = qmul(ky, wr);
        v[4] = qmul(-kx, pi);
        v[5] = qmul(kx, pr);
        v[6] = qmul(-ky, pi);
        v[7] = qmul(ky, pr);
        nk = qmul(longint'(nu_reg), ksq);
        v[8] = qmul(-nk, wr);
        v[9] = qmul(-nk, wi);
        for (int n = 0; n < 10; n++) r.val[n] = v[n][31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_deriv_item exp_item;
        logic [31:0] got[10];
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            dt_reg <= RST_TIME_STEP;
            nu_reg <= RST_VISCOSITY;
            scale_x_reg <= RST_WAVE_X;
            scale_y_reg <= RST_WAVE_Y;
            expected_derivs.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_TIME_STEP: dt_reg <= pwdata[30:0];
                    REG_VISCOSITY: nu_reg <= pwdata[30:0];
                    REG_WAVE_X: scale_x_reg <= pwdata[30:0];
                    REG_WAVE_Y: scale_y_reg <= pwdata[30:0];
                    default: ;
                endcase
            end
            if (i_modes.valid && i_modes.ready) begin
                expected_derivs.push_back(mode_derivs(i_modes.mode_x, i_modes.mode_y,
                    i_modes.stage, i_modes.vort_re, i_modes.vort_im, i_modes.slope_re,
                    i_modes.slope_im));
            end
            if (i_derivs.valid && i_derivs.ready) begin
                got = '{i_derivs.dvort_dx_re, i_derivs.dvort_dx_im, i_derivs.dvort_dy_re,
                        i_derivs.dvort_dy_im, i_derivs.dstream_dx_re, i_derivs.dstream_dx_im,
                        i_derivs.dstream_dy_re, i_derivs.dstream_dy_im,
                        i_derivs.diffusion_re, i_derivs.diffusion_im};
                if (expected_derivs.size() == 0) begin
                    $display("%0t: output item with none expected", $time);
                    errs++;
                end else begin
                    exp_item = expected_derivs.pop_front();
                    if (exp_item.band !== i_derivs.in_zero_band) begin
                        $display("%0t: in_zero_band expected %0b actual %0b", $time,
                                 exp_item.band, i_derivs.in_zero_band);
                        errs++;
                    end
                    for (int n = 0; n < 10; n++) begin
                        if (exp_item.val[n] !== got[n]) begin
                            $display("%0t: %s expected %h actual %h", $time,
                                     field_names[n], exp_item.val[n], got[n]);
                            errs++;
                        end
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending <= expected_derivs.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the spectral vorticity mode stage.
// ----------------------------------------------------------------------------
// Drives directed modes (zero mode, band edges, wrap-around, out-of-range
// indexes, every stage, extreme values) and then random modes over six
// register settings, with sender and receiver stalls in three patterns.
// The checker beside the block predicts and compares every output item.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import svm_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;

    svm_in_if  mode_ch ();
    svm_out_if deriv_ch ();

    spectral_vorticity_mode_stage dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (mode_ch),
        .o_out   (deriv_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    svm_mode_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_modes      (mode_ch),
        .i_derivs     (deriv_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("spectral_vorticity_mode_stage test failed");
        $finish;
    end

    always @(negedge i_clk) begin
        deriv_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_mode(logic [6:0] mx, logic [5:0] my, logic [1:0] stg,
                             logic [31:0] vr, logic [31:0] vi, logic [31:0] sr,
                             logic [31:0] si);
        while ($urandom_range(99) < send_idle_pct) begin
            mode_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        mode_ch.valid = 1'b1;
        mode_ch.mode_x = mx;
        mode_ch.mode_y = my;
        mode_ch.stage = stg;
        mode_ch.vort_re = vr;
        mode_ch.vort_im = vi;
        mode_ch.slope_re = sr;
        mode_ch.slope_im = si;
        do @(posedge i_clk); while (!mode_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        mode_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(2097151) - 32'd1048576;
            2: return 32'h7FFFFFFF;
            3: return 32'h80000000;
            4: return $urandom_range(262143) - 32'd131072;
            default: return $urandom_range(2) - 32'd1;
        endcase
    endfunction

    task automatic send_random();
        logic [6:0] mx;
        logic [5:0] my;
        if ($urandom_range(99) < 70) begin
            mx = $urandom_range(1) ? 7'($urandom_range(BAND_X_LO))
                                   : 7'($urandom_range(PAD_X - 1, GRID_X + 1));
            my = 6'($urandom_range(BAND_Y));
        end else begin
            mx = 7'($urandom);
            my = 6'($urandom);
        end
        send_mode(mx, my, 2'($urandom), rand_q(), rand_q(), rand_q(), rand_q());
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mode_ch.valid = 1'b0;
        mode_ch.mode_x = '0;
        mode_ch.mode_y = '0;
        mode_ch.stage = STAGE_PLAIN;
        mode_ch.vort_re = '0;
        mode_ch.vort_im = '0;
        mode_ch.slope_re = '0;
        mode_ch.slope_im = '0;
        deriv_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_mode(7'd0, 6'd0, STAGE_PLAIN, 32'h00010000, 32'hFFFF0000, 32'd0, 32'd0);
        send_mode(7'd1, 6'd0, STAGE_HALF_A, 32'h7FFFFFFF, 32'h80000000,
                  32'h7FFFFFFF, 32'h80000000);
        send_mode(7'd32, 6'd32, STAGE_HALF_B, 32'h80000000, 32'h7FFFFFFF,
                  32'h80000000, 32'h7FFFFFFF);
        send_mode(7'd33, 6'd0, STAGE_FULL, 32'h12345678, 32'h9ABCDEF0, 32'd1, 32'd1);
        send_mode(7'd64, 6'd5, STAGE_PLAIN, 32'h00010000, 32'h00010000, 32'd0, 32'd0);
        send_mode(7'd65, 6'd1, STAGE_FULL, 32'h7FFFFFFF, 32'h80000000,
                  32'h7FFFFFFF, 32'h80000000);
        send_mode(7'd48, 6'd3, STAGE_HALF_A, 32'h00020000, 32'hFFFE0000,
                  32'h00010000, 32'hFFFF0000);
        send_mode(7'd49, 6'd2, STAGE_HALF_B, 32'hFFFFFFFF, 32'h00000001,
                  32'hFFFFFFFF, 32'h00000001);
        send_mode(7'd95, 6'd32, STAGE_FULL, 32'h00008000, 32'hFFFF8000,
                  32'h00008000, 32'hFFFF8000);
        send_mode(7'd96, 6'd0, STAGE_PLAIN, 32'h00010000, 32'd0, 32'd0, 32'd0);
        send_mode(7'd127, 6'd63, STAGE_FULL, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  32'hFFFFFFFF, 32'hFFFFFFFF);
        send_mode(7'd0, 6'd33, STAGE_PLAIN, 32'h00010000, 32'd0, 32'd0, 32'd0);
        send_mode(7'd0, 6'd48, STAGE_PLAIN, 32'h00010000, 32'd0, 32'd0, 32'd0);
        send_mode(7'd0, 6'd49, STAGE_PLAIN, 32'h00010000, 32'd0, 32'd0, 32'd0);
        send_mode(7'd0, 6'd32, STAGE_PLAIN, 32'h7FFFFFFF, 32'h80000000, 32'd0, 32'd0);
        send_mode(7'd0, 6'd1, STAGE_FULL, 32'd0, 32'd0, 32'h7FFFFFFF, 32'h80000000);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: begin
                    write_reg(REG_TIME_STEP, 32'h7FFFFFFF);
                    write_reg(REG_VISCOSITY, 32'h7FFFFFFF);
                    write_reg(REG_WAVE_X, 32'h7FFFFFFF);
                    write_reg(REG_WAVE_Y, 32'h7FFFFFFF);
                end
                2: begin
                    write_reg(REG_TIME_STEP, 32'd0);
                    write_reg(REG_VISCOSITY, 32'd0);
                    write_reg(REG_WAVE_X, 32'd0);
                    write_reg(REG_WAVE_Y, 32'd0);
                end
                3: begin
                    write_reg(REG_TIME_STEP, $urandom_range(65536));
                    write_reg(REG_VISCOSITY, $urandom_range(65536));
                    write_reg(REG_WAVE_X, $urandom_range(262144));
                    write_reg(REG_WAVE_Y, $urandom_range(262144));
                end
                4: begin
                    write_reg(REG_TIME_STEP, $urandom_range(2047));
                    write_reg(REG_VISCOSITY, $urandom_range(255));
                    write_reg(REG_WAVE_X, $urandom_range(32767));
                    write_reg(REG_WAVE_Y, $urandom_range(32767));
                end
                5: begin
                    write_reg(REG_TIME_STEP, $urandom);
                    write_reg(REG_VISCOSITY, $urandom);
                    write_reg(REG_WAVE_X, $urandom);
                    write_reg(REG_WAVE_Y, $urandom);
                end
                default: ;
            endcase
            for (int pat = 0; pat < 3; pat++) begin
                send_idle_pct = (pat == 0) ? 11 : (pat == 1) ? 86 : 0;
                recv_idle_pct = (pat == 0) ? 86 : (pat == 1) ? 11 : 0;
                repeat (36) send_random();
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("spectral_vorticity_mode_stage test passed");
        end else begin
            $display("spectral_vorticity_mode_stage test failed");
        end
        $finish;
    end

endmodule
